### sv/drf_pkg.sv
`default_nettype none

package drf_pkg;

   localparam int unsigned ADDR_W                = 64;
   localparam int unsigned ID_W                  = 32;
   localparam int unsigned TIME_W                = 64;
   localparam int unsigned LIFETIME_W            = 20;
   localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 20'd30000;
   localparam int unsigned TABLE_ENTRIES_DEFAULT = 5;

   typedef struct packed {
      logic [ADDR_W-1:0] originator_addr;
      logic [ID_W-1:0]   request_id;
      logic [TIME_W-1:0] now_ms;
   } item_type;

   // handshake between the input stage, the table and the result stage
   typedef struct packed {
      logic item_valid;
      logic out_free;
   } flow_type;

endpackage

`default_nettype wire

### sv/drf_if.sv
`default_nettype none

interface drf_req_if;
   logic                          valid;
   logic                          ready;
   logic [drf_pkg::ADDR_W-1:0]    originator_addr;
   logic [drf_pkg::ID_W-1:0]      request_id;
   logic [drf_pkg::TIME_W-1:0]    now_ms;

   modport source (output valid, originator_addr, request_id, now_ms, input ready);
   modport sink   (input valid, originator_addr, request_id, now_ms, output ready);
endinterface

interface drf_rsp_if;
   logic valid;
   logic ready;
   logic seen_before;

   modport source (output valid, seen_before, input ready);
   modport sink   (input valid, seen_before, output ready);
endinterface

interface drf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [drf_pkg::LIFETIME_W-1:0]    lifetime_ms;

   modport source (output valid, lifetime_ms, input ready);
   modport sink   (input valid, lifetime_ms, output ready);
endinterface

`default_nettype wire

### sv/drf_in_stage.sv
`default_nettype none

module drf_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire drf_pkg::item_type req_item,
   input  wire logic              advance,
   output logic                   item_valid,
   output drf_pkg::item_type      item
);

   logic              vld_ff, vld_in;
   drf_pkg::item_type item_ff, item_in;
   logic              take;

   assign req_ready = ~reset & (~vld_ff | advance);
   assign take      = req_valid & req_ready;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (take) begin
         vld_in  = 1'b1;
         item_in = req_item;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### sv/drf_table.sv
`default_nettype none

module drf_table #(
   parameter int unsigned TABLE_ENTRIES = drf_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           update,
   input  wire drf_pkg::item_type              item,
   input  wire logic [drf_pkg::LIFETIME_W-1:0] lifetime_ms,
   output logic                                seen_before
);

   logic [TABLE_ENTRIES-1:0]        valid_ff, valid_in;
   logic [drf_pkg::ADDR_W-1:0]      addr_ff [TABLE_ENTRIES];
   logic [drf_pkg::ID_W-1:0]        id_ff   [TABLE_ENTRIES];
   logic [drf_pkg::TIME_W-1:0]      time_ff [TABLE_ENTRIES];

   logic [drf_pkg::TIME_W-1:0]      age   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]        live, hit, free, slot;

   always_comb begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         age[k]  = item.now_ms - time_ff[k];
         // kept while age <= lifetime
         live[k] = valid_ff[k]
                   & (age[k][drf_pkg::TIME_W-1:drf_pkg::LIFETIME_W] == '0)
                   & (age[k][drf_pkg::LIFETIME_W-1:0] <= lifetime_ms);
         hit[k]  = live[k] & (addr_ff[k] == item.originator_addr)
                   & (id_ff[k] == item.request_id);
      end
   end

   assign seen_before = |hit;
   assign free        = ~live;
   assign slot        = free & (~free + TABLE_ENTRIES'(1));

   always_comb begin
      valid_in = valid_ff;
      if (update) begin
         valid_in = seen_before ? live : (live | slot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (update & ~seen_before & slot[k]) begin
            addr_ff[k] <= item.originator_addr;
            id_ff[k]   <= item.request_id;
            time_ff[k] <= item.now_ms;
         end
      end
   end

endmodule

`default_nettype wire

### sv/drf_out_stage.sv
`default_nettype none

module drf_out_stage (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  wire logic seen_in,
   input  wire logic rsp_ready,
   output logic      rsp_valid,
   output logic      rsp_seen,
   output logic      out_free
);

   logic vld_ff, vld_in;
   logic seen_ff, seen_ff_in;

   assign out_free = ~vld_ff | rsp_ready;

   always_comb begin
      vld_in     = vld_ff;
      seen_ff_in = seen_ff;
      if (load) begin
         vld_in     = 1'b1;
         seen_ff_in = seen_in;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      seen_ff <= seen_ff_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_seen  = seen_ff;

endmodule

`default_nettype wire

### sv/duplicate_request_filter_unit.sv
// A taken request waits in the input register, then passes the table lookup
// into the result register. Throughput: one request per cycle while results
// are taken, set by the combinational table lookup and update in between.
// Reset (synchronous): table all invalid, lifetime_ms back to 30000,
// both stages empty; no transfers are taken while reset is high.
`default_nettype none

module duplicate_request_filter_unit #(
   parameter int unsigned TABLE_ENTRIES = drf_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   drf_req_if.sink   req_chan,
   drf_rsp_if.source rsp_chan,
   drf_csr_if.sink   csr_chan
);

   logic [drf_pkg::LIFETIME_W-1:0] lifetime_ff, lifetime_in;
   drf_pkg::item_type              req_item, item;
   drf_pkg::flow_type              flow;
   logic                           advance;
   logic                           seen;

   assign csr_chan.ready = ~reset;
   assign lifetime_in    = (csr_chan.valid & csr_chan.ready) ? csr_chan.lifetime_ms
                                                             : lifetime_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= drf_pkg::LIFETIME_RESET;
      end else begin
         lifetime_ff <= lifetime_in;
      end
   end

   assign req_item.originator_addr = req_chan.originator_addr;
   assign req_item.request_id      = req_chan.request_id;
   assign req_item.now_ms          = req_chan.now_ms;

   assign advance = flow.item_valid & flow.out_free;

   drf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (flow.item_valid),
      .item       (item)
   );

   drf_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .item        (item),
      .lifetime_ms (lifetime_ff),
      .seen_before (seen)
   );

   drf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .seen_in   (seen),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_seen  (rsp_chan.seen_before),
      .out_free  (flow.out_free)
   );

endmodule

`default_nettype wire

### sv/drf_checker.sv
`default_nettype none

module drf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_seen
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_from_req : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("new result without a request transfer two cycles earlier");

   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled while the result side is free");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_seen)))
      else $error("stalled result changed");

endmodule

bind duplicate_request_filter_unit drf_checker u_drf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_seen  (rsp_chan.seen_before)
);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int TABLE_SLOTS = drf_pkg::TABLE_ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PARK_CYCLES = 200;
   localparam int POOL_SIZE = 8;

   class rreq_dup_table;
      logic [drf_pkg::LIFETIME_W-1:0] lifetime = drf_pkg::LIFETIME_RESET;
      bit                             slot_used[TABLE_SLOTS] = '{default: 1'b0};
      logic [drf_pkg::ADDR_W-1:0]     slot_addr[TABLE_SLOTS];
      logic [drf_pkg::ID_W-1:0]       slot_id[TABLE_SLOTS];
      logic [drf_pkg::TIME_W-1:0]     slot_time[TABLE_SLOTS];
      bit                             seen_expected_q[$];
      int                             errors = 0;

      function void note_request(input drf_pkg::item_type it);
         logic [drf_pkg::TIME_W-1:0] age;
         bit                         hit;
         bit                         stored;
         hit = 1'b0;
         stored = 1'b0;
         for (int k = 0; k < TABLE_SLOTS; k++) begin
            age = it.now_ms - slot_time[k];
            if (slot_used[k] &&
                age > {{(drf_pkg::TIME_W-drf_pkg::LIFETIME_W){1'b0}}, lifetime}) begin
               slot_used[k] = 1'b0;
            end
         end
         for (int k = 0; k < TABLE_SLOTS; k++) begin
            if (slot_used[k] && slot_addr[k] == it.originator_addr &&
                slot_id[k] == it.request_id) begin
               hit = 1'b1;
            end
         end
         if (!hit) begin
            for (int k = 0; k < TABLE_SLOTS; k++) begin
               if (!stored && !slot_used[k]) begin
                  slot_used[k] = 1'b1;
                  slot_addr[k] = it.originator_addr;
                  slot_id[k] = it.request_id;
                  slot_time[k] = it.now_ms;
                  stored = 1'b1;
               end
            end
         end
         seen_expected_q.push_back(hit);
      endfunction

      function void check_seen(input logic got);
         bit want;
         if (seen_expected_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual seen_before=%0b",
                     $time, got);
            errors++;
         end else begin
            want = seen_expected_q.pop_front();
            if (got !== want) begin
               $display("%0t: seen_before expected %0b actual %0b", $time, want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return seen_expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   bit          quiet = 1'b0;
   bit          park_rsp = 1'b0;
   int unsigned cycle_count = 0;

   logic [drf_pkg::LIFETIME_W-1:0] life_now = drf_pkg::LIFETIME_RESET;
   logic [drf_pkg::TIME_W-1:0]     wall_ms;
   logic [drf_pkg::ADDR_W-1:0]     pool_addr[POOL_SIZE];
   logic [drf_pkg::ID_W-1:0]       pool_id[POOL_SIZE];

   rreq_dup_table dup_table = new();

   drf_req_if req_chan();
   drf_rsp_if rsp_chan();
   drf_csr_if csr_chan();

   duplicate_request_filter_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         dup_table.check_seen(rsp_chan.seen_before);
      end
   end

   // result side pacing: random stalls, one long park on request
   initial begin : rsp_pacer
      int n;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (park_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (PARK_CYCLES) @(posedge clock);
            park_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 40);
            rsp_chan.ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic put_request(input logic [drf_pkg::ADDR_W-1:0] addr,
                              input logic [drf_pkg::ID_W-1:0] id,
                              input logic [drf_pkg::TIME_W-1:0] now);
      drf_pkg::item_type it;
      int                gap;
      it.originator_addr = addr;
      it.request_id = id;
      it.now_ms = now;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.originator_addr <= addr;
      req_chan.request_id <= id;
      req_chan.now_ms <= now;
      do @(posedge clock); while (!req_chan.ready);
      dup_table.note_request(it);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (dup_table.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_lifetime(input logic [drf_pkg::LIFETIME_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.lifetime_ms <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      dup_table.lifetime = value;
      life_now = value;
      @(posedge clock);
   endtask

   function automatic logic [drf_pkg::TIME_W-1:0] next_step();
      logic [drf_pkg::TIME_W-1:0] step;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5:           step = '0;
         6, 7, 8, 9, 10, 11, 12, 13: step = 64'($urandom_range(0, life_now / 3 + 1));
         14, 15, 16, 17:             step = {44'b0, life_now} + 64'($urandom_range(0, 2));
         18:                         step = -(64'($urandom_range(1, 40)));
         default:                    step = {$urandom, $urandom};
      endcase
      return step;
   endfunction

   function automatic void refill_pool();
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_addr[k] = {$urandom, $urandom};
         pool_id[k] = $urandom;
      end
      // pairs sharing one field only
      pool_addr[1] = pool_addr[0];
      pool_id[3] = pool_id[2];
      if ($urandom_range(0, 1) == 0) begin
         pool_addr[5] = '0;
         pool_id[6] = '1;
      end
   endfunction

   task automatic run_phase(input int count);
      logic [drf_pkg::ADDR_W-1:0] addr;
      logic [drf_pkg::ID_W-1:0]   id;
      int                         pick;
      refill_pool();
      case ($urandom_range(0, 2))
         0:       wall_ms = {$urandom, $urandom};
         1:       wall_ms = '1 - 64'($urandom_range(0, 2000000));
         default: wall_ms = 64'($urandom_range(0, 100000));
      endcase
      for (int n = 0; n < count; n++) begin
         wall_ms = wall_ms + next_step();
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            addr = pool_addr[$urandom_range(0, POOL_SIZE - 1)];
            id = pool_id[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 11) begin
               pick = $urandom_range(0, POOL_SIZE - 1);
               addr = pool_addr[pick];
               id = pool_id[pick];
            end
         end else if (pick < 17) begin
            addr = pool_addr[$urandom_range(0, POOL_SIZE - 1)];
            id = $urandom;
         end else begin
            addr = {$urandom, $urandom};
            id = $urandom;
         end
         put_request(addr, id, wall_ms);
      end
   endtask

   initial begin : stimulus
      req_chan.valid <= 1'b0;
      req_chan.originator_addr <= '0;
      req_chan.request_id <= '0;
      req_chan.now_ms <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.lifetime_ms <= '0;
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default lifetime: duplicates, exact-age boundary, full table
      put_request('0, '0, 64'd0);
      put_request('0, '0, 64'd0);
      put_request('1, '1, 64'd30000);
      put_request('0, '0, 64'd30000);
      put_request('1, '0, 64'd30001);
      put_request('0, '1, 64'd30001);
      put_request(64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, 64'd30002);
      put_request(64'h5A5A_5A5A_5A5A_5A5A, 32'hA5A5_A5A5, 64'd30003);
      put_request(64'd1, 32'd1, 64'd30004);
      put_request(64'd1, 32'd1, 64'd30005);
      put_request('1, '1, 64'd30005);
      // time running backwards, then the top of the time range and wrap
      put_request('0, '1, 64'd100);
      put_request('0, '1, 64'd100);
      put_request('1, '1, '1);
      put_request('1, '1, '1);
      put_request('0, '0, 64'd0);
      put_request('1, '1, 64'd1);

      wait_idle();
      write_lifetime('0);
      put_request(64'd7, 32'd7, 64'd500);
      put_request(64'd7, 32'd7, 64'd500);
      put_request(64'd7, 32'd7, 64'd501);

      wait_idle();
      write_lifetime('1);
      put_request(64'd9, 32'd9, 64'd1000);
      put_request(64'd9, 32'd9, 64'd1000 + 64'hF_FFFF);
      put_request(64'd9, 32'd9, 64'd1001 + 64'hF_FFFF);

      wait_idle();
      write_lifetime(drf_pkg::LIFETIME_RESET);
      park_rsp = 1'b1;
      run_phase(200);

      wait_idle();
      write_lifetime('0);
      run_phase(150);

      wait_idle();
      write_lifetime('1);
      run_phase(200);

      wait_idle();
      write_lifetime(20'd1);
      run_phase(150);

      wait_idle();
      write_lifetime(20'($urandom_range(0, 5000)));
      run_phase(200);

      wait_idle();
      quiet = 1'b1;
      write_lifetime(20'($urandom_range(2, 300)));
      run_phase(300);

      wait_idle();
      repeat (20) @(posedge clock);
      if (dup_table.errors == 0 && dup_table.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
sv/drf_pkg.sv
sv/drf_if.sv
sv/drf_in_stage.sv
sv/drf_table.sv
sv/drf_out_stage.sv
sv/duplicate_request_filter_unit.sv
sv/drf_checker.sv
test/tb.sv
